// File: sv/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Shared constants and types of the descriptor medoid select unit.
// ----------------------------------------------------------------------------
package dms_pkg;

	localparam int MAX_OBS    = 32;
	localparam int WORD_W     = 64;
	localparam int DESC_WORDS = 4;
	localparam int DESC_W     = WORD_W * DESC_WORDS;
	localparam int SLOT_W     = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
	localparam int CNT_W      = $clog2(MAX_OBS + 1);
	localparam int DIST_W     = 9;
	localparam int PC_W       = 7;
	localparam int INDEX_W    = 5;
	localparam int Q_DEPTH    = 2;

	// Command from the front end to the back end.
	typedef struct packed {
		logic              store;
		logic              last;
		logic              bad;
		logic [CNT_W-1:0]  n;
		logic [SLOT_W-1:0] slot;
		logic [DESC_W-1:0] data;
	} dms_cmd_t;

endpackage

// File: sv/dms_in_if.sv
// ----------------------------------------------------------------------------
// dms_in_if
// Descriptor input channel: one descriptor per beat.
// ----------------------------------------------------------------------------
interface dms_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] desc_word0;
	logic [63:0] desc_word1;
	logic [63:0] desc_word2;
	logic [63:0] desc_word3;
	logic        observer_bad;
	logic        last_item;

	modport source (output valid, desc_word0, desc_word1, desc_word2, desc_word3,
		observer_bad, last_item, input ready);
	modport sink (input valid, desc_word0, desc_word1, desc_word2, desc_word3,
		observer_bad, last_item, output ready);
endinterface

// File: sv/dms_out_if.sv
// ----------------------------------------------------------------------------
// dms_out_if
// Result channel: one chosen descriptor per beat.
// ----------------------------------------------------------------------------
interface dms_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [4:0]  chosen_index;
	logic [63:0] out_word0;
	logic [63:0] out_word1;
	logic [63:0] out_word2;
	logic [63:0] out_word3;

	modport source (output valid, found, chosen_index, out_word0, out_word1, out_word2,
		out_word3, input ready);
	modport sink (input valid, found, chosen_index, out_word0, out_word1, out_word2,
		out_word3, output ready);
endinterface

// File: sv/dms_ram.sv
// ----------------------------------------------------------------------------
// dms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/dms_queue.sv
// ----------------------------------------------------------------------------
// dms_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dms_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  dms_pkg::dms_cmd_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output dms_pkg::dms_cmd_t pop_data
);
	localparam int AW = (dms_pkg::Q_DEPTH > 1) ? $clog2(dms_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(dms_pkg::Q_DEPTH + 1);

	dms_pkg::dms_cmd_t slots_q [dms_pkg::Q_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = (count_q != CW'(dms_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(dms_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(dms_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

// File: sv/dms_front.sv
// ----------------------------------------------------------------------------
// dms_front
// Accepts descriptors, drops bad ones and overflow, numbers the good ones
// and turns each beat into a store and/or end-of-set command.
// ----------------------------------------------------------------------------
module dms_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	dms_in_if.sink            items,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output dms_pkg::dms_cmd_t cmd
);
	logic [dms_pkg::CNT_W-1:0] cnt_q;
	logic                      point_bad_q;
	logic                      store;
	logic [dms_pkg::CNT_W-1:0] n_next;
	logic                      accept;

	assign store  = !items.observer_bad && (cnt_q < dms_pkg::CNT_W'(dms_pkg::MAX_OBS));
	assign n_next = store ? cnt_q + dms_pkg::CNT_W'(1) : cnt_q;

	// Beats that neither store nor close a set are accepted and dropped.
	assign items.ready = cmd_ready;
	assign accept      = items.valid && cmd_ready;
	assign cmd_valid   = items.valid && (store || items.last_item);

	always_comb begin
		cmd.store = store;
		cmd.last  = items.last_item;
		cmd.bad   = point_bad_q;
		cmd.n     = n_next;
		cmd.slot  = cnt_q[dms_pkg::SLOT_W-1:0];
		cmd.data  = {items.desc_word3, items.desc_word2, items.desc_word1, items.desc_word0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			point_bad_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_bad_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q <= items.last_item ? '0 : n_next;
			end
		end
	end
endmodule

// File: sv/dms_back.sv
// ----------------------------------------------------------------------------
// dms_back
// Stores descriptors and, at the end of a set, finds the descriptor whose
// median Hamming distance to the set is smallest, one row at a time.
// ----------------------------------------------------------------------------
module dms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dms_pkg::dms_cmd_t cmd,
	dms_out_if.source         results
);
	localparam int SW = dms_pkg::SLOT_W;
	localparam int CW = dms_pkg::CNT_W;
	localparam int DW = dms_pkg::DIST_W;
	localparam int PW = dms_pkg::PC_W;
	localparam int WW = dms_pkg::WORD_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ROW_RD, S_ROW_LAT, S_DIST, S_MED_A, S_MED_B, S_OUT_RD, S_OUT_LAT, S_OUT
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              n_q, jr_q, wcnt_q;
	logic [SW-1:0]              row_q, k_q, best_slot_q;
	logic [DW-1:0]              best_med_q, dk_q;
	logic [dms_pkg::DESC_W-1:0] rowdesc_q;
	logic [DW-1:0]              rowbuf_q [dms_pkg::MAX_OBS];
	logic [dms_pkg::MAX_OBS-1:0] lt_q, le_q;
	logic                       v_s1, v_s2;
	logic [SW-1:0]              idx_s1, idx_s2;
	logic [PW-1:0]              pc_s2 [dms_pkg::DESC_WORDS];
	logic [dms_pkg::DESC_W-1:0] rdata;
	logic [SW-1:0]              raddr;
	logic                       ram_we;
	logic [DW-1:0]              dist_sum;
	logic [CW-1:0]              lt_cnt, le_cnt, mid;
	logic                       found_q;
	logic [dms_pkg::INDEX_W-1:0] index_q;
	logic [dms_pkg::DESC_W-1:0] word_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign ram_we    = cmd_valid && cmd_ready && cmd.store;

	always_comb begin
		case (state_q)
			S_ROW_RD: raddr = row_q;
			S_DIST:   raddr = jr_q[SW-1:0];
			S_OUT_RD: raddr = best_slot_q;
			default:  raddr = row_q;
		endcase
	end

	dms_ram #(.WIDTH(dms_pkg::DESC_W), .DEPTH(dms_pkg::MAX_OBS)) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.slot),
		.wdata (cmd.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		dist_sum = '0;
		for (int w = 0; w < dms_pkg::DESC_WORDS; w++) begin
			dist_sum = dist_sum + DW'(pc_s2[w]);
		end
	end

	assign lt_cnt = CW'($countones(lt_q));
	assign le_cnt = CW'($countones(le_q));
	assign mid    = n_q >> 1;

	// Distance pipeline: memory read, per-word population count, sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_DIST) && (jr_q < n_q);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= jr_q[SW-1:0];
		idx_s2 <= idx_s1;
		for (int w = 0; w < dms_pkg::DESC_WORDS; w++) begin
			pc_s2[w] <= PW'($countones(rdata[w*WW +: WW] ^ rowdesc_q[w*WW +: WW]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			jr_q        <= '0;
			wcnt_q      <= '0;
			row_q       <= '0;
			k_q         <= '0;
			best_slot_q <= '0;
			best_med_q  <= '1;
			dk_q        <= '0;
			rowdesc_q   <= '0;
			lt_q        <= '0;
			le_q        <= '0;
			found_q     <= 1'b0;
			index_q     <= '0;
			word_q      <= '0;
			for (int j = 0; j < dms_pkg::MAX_OBS; j++) begin
				rowbuf_q[j] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.last) begin
						if (cmd.bad || cmd.n == '0) begin
							found_q <= 1'b0;
							index_q <= '0;
							word_q  <= '0;
							state_q <= S_OUT;
						end else begin
							n_q         <= cmd.n;
							row_q       <= '0;
							best_med_q  <= '1;
							best_slot_q <= '0;
							state_q     <= S_ROW_RD;
						end
					end
				end
				S_ROW_RD: begin
					state_q <= S_ROW_LAT;
				end
				S_ROW_LAT: begin
					rowdesc_q <= rdata;
					jr_q      <= '0;
					wcnt_q    <= '0;
					state_q   <= S_DIST;
				end
				S_DIST: begin
					if (jr_q < n_q) begin
						jr_q <= jr_q + CW'(1);
					end
					if (v_s2) begin
						rowbuf_q[idx_s2] <= dist_sum;
						wcnt_q <= wcnt_q + CW'(1);
						if (wcnt_q + CW'(1) == n_q) begin
							k_q     <= '0;
							state_q <= S_MED_A;
						end
					end
				end
				S_MED_A: begin
					for (int j = 0; j < dms_pkg::MAX_OBS; j++) begin
						lt_q[j] <= (CW'(j) < n_q) && (rowbuf_q[j] < rowbuf_q[k_q]);
						le_q[j] <= (CW'(j) < n_q) && (rowbuf_q[j] <= rowbuf_q[k_q]);
					end
					dk_q    <= rowbuf_q[k_q];
					state_q <= S_MED_B;
				end
				S_MED_B: begin
					// The candidate is the median when it spans sorted position n/2.
					if (lt_cnt <= mid && le_cnt > mid) begin
						if (row_q == '0 || dk_q < best_med_q) begin
							best_med_q  <= dk_q;
							best_slot_q <= row_q;
						end
						if (CW'(row_q) + CW'(1) == n_q) begin
							state_q <= S_OUT_RD;
						end else begin
							row_q   <= row_q + SW'(1);
							state_q <= S_ROW_RD;
						end
					end else begin
						k_q     <= k_q + SW'(1);
						state_q <= S_MED_A;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LAT;
				end
				S_OUT_LAT: begin
					found_q <= 1'b1;
					index_q <= dms_pkg::INDEX_W'(best_slot_q);
					word_q  <= rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid        = (state_q == S_OUT);
	assign results.found        = found_q;
	assign results.chosen_index = index_q;
	assign results.out_word0    = word_q[0*WW +: WW];
	assign results.out_word1    = word_q[1*WW +: WW];
	assign results.out_word2    = word_q[2*WW +: WW];
	assign results.out_word3    = word_q[3*WW +: WW];
endmodule

// File: sv/descriptor_medoid_select_unit.sv
// ----------------------------------------------------------------------------
// descriptor_medoid_select_unit
// Picks the representative descriptor of a set by smallest median distance.
// ----------------------------------------------------------------------------
// Descriptors are taken one beat per cycle while the two-entry command queue
// has room; beats from bad observers and beyond 32 good ones are dropped. On
// the beat marked last, the back end evaluates the set of n good descriptors
// row by row through the single read port of the descriptor memory: each row
// streams its distances through the distance pipeline and then tries median
// candidates (1 to n) in turn; while a set is evaluated, new beats only fill
// the queue. A bad point or an empty set gives a result with found cleared.
module descriptor_medoid_select_unit (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	dms_in_if.sink    items,
	dms_out_if.source results
);
	dms_pkg::dms_cmd_t front_cmd, back_cmd;
	logic              front_valid, front_ready, back_valid, back_ready;

	dms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	dms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	dms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.results   (results)
	);
endmodule

// File: test/descriptor_medoid_select_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_medoid_select_unit_tb
// Self-checking bench for the descriptor medoid select unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked descriptor sets runs first, then random sets of
// mostly small size with some past the 32-descriptor limit. Every accepted beat
// goes into a behavioral predictor. Each result beat is checked against the
// oldest predicted result. The run covers phases of sender gaps and receiver
// stalls, one long receiver hold-off, and both settings of the bad-point flag.
// ----------------------------------------------------------------------------
module descriptor_medoid_select_unit_tb;

	localparam int LIMIT       = 1500000;
	localparam int SET_LATENCY = 3300;
	localparam int HOLD_CYCLES = 4000;

	typedef struct packed {
		logic                       found;
		logic [4:0]                 idx;
		logic [dms_pkg::DESC_W-1:0] d;
	} pick_t;

	typedef struct {
		logic [dms_pkg::DESC_W-1:0] d;
		bit                         bad;
		bit                         last;
		int                         pb;
		bit                         typed;
		pick_t                      want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dms_in_if  items ();
	dms_out_if results ();

	descriptor_medoid_select_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (items.sink),
		.results  (results.source)
	);

	// Predictor state.
	logic [dms_pkg::DESC_W-1:0] desc_bank [dms_pkg::MAX_OBS];
	int                bank_count;
	bit                point_bad_shadow;

	pick_t pending_picks [$];
	row_t  table_rows [$];
	int    errors;
	int    cycles;
	int    idle_mode;
	int    hold_reqs;
	int    hold_seen;
	int    hold_left;
	logic [dms_pkg::DESC_W-1:0] last_desc;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [dms_pkg::DESC_W-1:0] rand_desc();
		logic [dms_pkg::DESC_W-1:0] v;
		for (int k = 0; k < dms_pkg::DESC_W / 32; k++)
			v[k*32 +: 32] = $urandom;
		return v;
	endfunction

	// Updates the bank and, on the last beat of a set, works out its medoid.
	task automatic medoid_predict(input logic [dms_pkg::DESC_W-1:0] d, input bit bad,
		input bit last, output bit has, output pick_t r);
		int n;
		int row [dms_pkg::MAX_OBS];
		int v;
		int j;
		int m;
		int best;
		int best_i;
		has = 1'b0;
		r = '0;
		if (!bad && bank_count < dms_pkg::MAX_OBS) begin
			desc_bank[bank_count] = d;
			bank_count++;
		end
		if (!last)
			return;
		has = 1'b1;
		n = bank_count;
		bank_count = 0;
		if (point_bad_shadow || n == 0)
			return;
		best = 0;
		best_i = 0;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < n; k++)
				row[k] = (i == k) ? 0 : $countones(desc_bank[i] ^ desc_bank[k]);
			for (int k = 1; k < n; k++) begin
				v = row[k];
				j = k;
				while (j > 0 && row[j-1] > v) begin
					row[j] = row[j-1];
					j--;
				end
				row[j] = v;
			end
			m = row[n/2];
			if (i == 0 || m < best) begin
				best = m;
				best_i = i;
			end
		end
		r.found = 1'b1;
		r.idx = best_i[4:0];
		r.d = desc_bank[best_i];
	endtask

	// Offers one descriptor beat and returns just after the edge that took it.
	task automatic send_desc(input logic [dms_pkg::DESC_W-1:0] d, input bit bad,
		input bit last, input bit typed, input pick_t want);
		int gap;
		bit has;
		pick_t r;
		gap = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 13 : 0;
		@(negedge clk);
		while ($urandom_range(99) < gap) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid        <= 1'b1;
		items.desc_word0   <= d[63:0];
		items.desc_word1   <= d[127:64];
		items.desc_word2   <= d[191:128];
		items.desc_word3   <= d[255:192];
		items.observer_bad <= bad;
		items.last_item    <= last;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		medoid_predict(d, bad, last, has, r);
		if (has)
			pending_picks = {pending_picks, (typed ? want : r)};
		last_desc = d;
	endtask

	// Lowers valid and waits until every predicted result has been seen.
	task automatic drain();
		@(negedge clk);
		items.valid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_point_bad(input bit v);
		drain();
		repeat (SET_LATENCY) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		point_bad_shadow = v;
	endtask

	task automatic add_row(input logic [dms_pkg::DESC_W-1:0] d, input bit bad, input bit last,
		input int pb, input bit typed, input pick_t want);
		row_t t;
		t.d = d;
		t.bad = bad;
		t.last = last;
		t.pb = pb;
		t.typed = typed;
		t.want = want;
		table_rows = {table_rows, t};
	endtask

	// Receiver: random stalls per phase, plus the long hold-off on request.
	always @(negedge clk) begin
		int stall;
		stall = (idle_mode == 2) ? 48 : (idle_mode == 3) ? 13 : 0;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
			results.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(99) >= stall);
		end
	end

	always @(posedge clk) begin
		pick_t e;
		if (arst_n && results.valid && results.ready) begin
			if (pending_picks.size() == 0) begin
				$error("result beat with no prediction waiting");
				errors++;
			end else begin
				e = pending_picks.pop_front();
				if (results.found !== e.found) begin
					$error("found: expected %0d got %0d", e.found, results.found);
					errors++;
				end
				if (results.chosen_index !== e.idx) begin
					$error("chosen_index: expected %0d got %0d", e.idx, results.chosen_index);
					errors++;
				end
				if (results.out_word0 !== e.d[63:0]) begin
					$error("out_word0: expected %h got %h", e.d[63:0], results.out_word0);
					errors++;
				end
				if (results.out_word1 !== e.d[127:64]) begin
					$error("out_word1: expected %h got %h", e.d[127:64], results.out_word1);
					errors++;
				end
				if (results.out_word2 !== e.d[191:128]) begin
					$error("out_word2: expected %h got %h", e.d[191:128], results.out_word2);
					errors++;
				end
				if (results.out_word3 !== e.d[255:192]) begin
					$error("out_word3: expected %h got %h", e.d[255:192], results.out_word3);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [dms_pkg::DESC_W-1:0] ones;
		logic [dms_pkg::DESC_W-1:0] d;
		pick_t none;
		pick_t w;
		int phase_mode [8];
		int phase_pb [8];
		int phase_items [8];
		int sent;
		int set_n;
		int roll;
		bit bad;

		ones = '1;
		none = '0;
		idle_mode = 0;
		hold_reqs = 0;
		bank_count = 0;
		point_bad_shadow = 1'b0;
		last_desc = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		items.valid = 1'b0;
		items.desc_word0 = '0;
		items.desc_word1 = '0;
		items.desc_word2 = '0;
		items.desc_word3 = '0;
		items.observer_bad = 1'b0;
		items.last_item = 1'b0;

		// Empty set, single descriptors at the extremes, then small mixed sets.
		add_row('0, 1, 1, -1, 1, none);
		w = '{1'b1, 5'd0, '0};
		add_row('0, 0, 1, -1, 1, w);
		w = '{1'b1, 5'd0, ones};
		add_row(ones, 0, 1, -1, 1, w);
		add_row(ones, 0, 0, -1, 0, none);
		add_row('0, 0, 0, -1, 0, none);
		add_row({8{32'hA5A5_5A5A}}, 0, 1, -1, 0, none);
		d = {8{32'h0123_4567}};
		w = '{1'b1, 5'd0, d};
		add_row(ones, 1, 0, -1, 0, none);
		add_row(d, 0, 1, -1, 1, w);
		add_row(ones, 0, 1, 1, 1, none);
		add_row(d, 0, 0, -1, 0, none);
		add_row('0, 1, 1, -1, 1, none);
		add_row('0, 0, 0, 0, 0, none);
		add_row('0, 0, 1, -1, 0, none);
		add_row({64{4'h5}}, 0, 0, -1, 0, none);
		add_row({64{4'hA}}, 0, 0, -1, 0, none);
		add_row({64{4'hF}}, 1, 0, -1, 0, none);
		add_row({32{8'h0F}}, 0, 1, -1, 0, none);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (table_rows[i]) begin
			if (table_rows[i].pb >= 0)
				write_point_bad(table_rows[i].pb[0]);
			send_desc(table_rows[i].d, table_rows[i].bad, table_rows[i].last,
				table_rows[i].typed, table_rows[i].want);
		end

		phase_mode  = '{0, 1, 2, 3, 0, 2, 1, 3};
		phase_pb    = '{0, 0, 1, 0, 0, 0, 1, 0};
		phase_items = '{220, 220, 60, 220, 200, 220, 60, 230};

		for (int p = 0; p < 8; p++) begin
			write_point_bad(phase_pb[p][0]);
			idle_mode = phase_mode[p];
			// One phase starves the receiver so the input queue fills up.
			if (p == 4)
				hold_reqs++;
			sent = 0;
			while (sent < phase_items[p]) begin
				roll = $urandom_range(99);
				set_n = (roll < 80) ? $urandom_range(1, 6) :
					(roll < 95) ? $urandom_range(7, 20) : $urandom_range(30, 40);
				for (int k = 0; k < set_n; k++) begin
					roll = $urandom_range(99);
					if (roll < 70) begin
						d = rand_desc();
					end else if (roll < 80) begin
						d = last_desc;
						repeat ($urandom_range(1, 4))
							d[$urandom_range(dms_pkg::DESC_W-1)] ^= 1'b1;
					end else if (roll < 90) begin
						d = '0;
					end else begin
						d = ones;
					end
					bad = ($urandom_range(99) < 15);
					send_desc(d, bad, k == set_n - 1, 0, none);
					sent++;
				end
			end
		end

		drain();
		repeat (SET_LATENCY) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
